@@ sv/card_number_luhn_brand_check_unit_macros.svh @@
// Assertion helpers shared by the RTL; every use samples on clk and is off in reset.
`ifndef CARD_NUMBER_LUHN_BRAND_CHECK_UNIT_MACROS_SVH
`define CARD_NUMBER_LUHN_BRAND_CHECK_UNIT_MACROS_SVH

// Same-cycle implication.
`define LBC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LBC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lbc_pkg.sv @@
`timescale 1ns / 1ps

package lbc_pkg;

  localparam int CARD_W         = 64;
  localparam int NUM_BCD        = 20;
  localparam int DIGIT_W        = 4;
  localparam int BCD_W          = NUM_BCD * DIGIT_W;
  localparam int SHIFT_CNT_W    = $clog2(CARD_W);
  localparam int IDX_W          = $clog2(NUM_BCD);
  localparam int COUNT_W        = 5;
  localparam int DEF_MAX_DIGITS = 19;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BCD - 1);

  // Lengths that the issuer classes allow.
  localparam logic [COUNT_W-1:0] LEN_LEAD4_SHORT = COUNT_W'(13);
  localparam logic [COUNT_W-1:0] LEN_LEAD4_LONG  = COUNT_W'(16);
  localparam logic [COUNT_W-1:0] LEN_LEAD3X      = COUNT_W'(15);
  localparam logic [COUNT_W-1:0] LEN_LEAD5X      = COUNT_W'(16);

  typedef logic [CARD_W-1:0]  card_t;
  typedef logic [BCD_W-1:0]   bcd_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    CLS_INVALID   = 2'd0,
    CLS_LEAD4     = 2'd1,
    CLS_LEAD34_37 = 2'd2,
    CLS_LEAD51_55 = 2'd3
  } class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Converter status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

  // Add 3 to every BCD digit of 5 or more before the next left shift.
  function automatic bcd_t bcd_adjust(bcd_t bcd);
    bcd_t res;
    res = bcd;
    for (int i = 0; i < NUM_BCD; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= digit_t'(5)) begin
        res[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + digit_t'(3);
      end
    end
    return res;
  endfunction

  // Issuer class from length and the two leading digits.
  function automatic class_t lbc_classify(count_t len, digit_t hi, digit_t lo);
    class_t cls;
    cls = CLS_INVALID;
    if ((len == LEN_LEAD4_SHORT || len == LEN_LEAD4_LONG) && hi == digit_t'(4)) begin
      cls = CLS_LEAD4;
    end else if (len == LEN_LEAD3X && hi == digit_t'(3) &&
                 (lo == digit_t'(4) || lo == digit_t'(7))) begin
      cls = CLS_LEAD34_37;
    end else if (len == LEN_LEAD5X && hi == digit_t'(5) &&
                 lo >= digit_t'(1) && lo <= digit_t'(5)) begin
      cls = CLS_LEAD51_55;
    end
    return cls;
  endfunction

endpackage

@@ sv/lbc_if.sv @@
`timescale 1ns / 1ps

interface lbc_in_if import lbc_pkg::*; ();
  logic  valid;
  logic  ready;
  card_t card_value;

  modport source (output valid, output card_value, input ready);
  modport sink   (input valid, input card_value, output ready);
endinterface

interface lbc_out_if import lbc_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   luhn_ok;
  count_t digit_count;
  class_t issuer_class;

  modport source (output valid, output luhn_ok, output digit_count, output issuer_class,
                  input ready);
  modport sink   (input valid, input luhn_ok, input digit_count, input issuer_class,
                  output ready);
endinterface

@@ sv/lbc_bcd_conv.sv @@
`timescale 1ns / 1ps

// Shift-and-add-3 binary to BCD, one bit per cycle.
module lbc_bcd_conv import lbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  card_t      value,
  output conv_stat_t stat,
  output bcd_t       bcd
);

  card_t                  bin_r, bin_nxt;
  bcd_t                   bcd_r, bcd_nxt;
  logic [SHIFT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  bcd_t                   adj;

  assign adj = bcd_adjust(bcd_r);

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[BCD_W-2:0], bin_r[CARD_W-1]};
      bin_nxt = {bin_r[CARD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == SHIFT_CNT_W'(CARD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

@@ sv/card_number_luhn_brand_check_unit.sv @@
// Flow: the input beat starts the converter, then the digit scan runs, then the
//   sequencer moves the result out; the shift-and-add-3 converter takes most of the time.
// One card number at a time: in_ch.ready is low from the input beat until the result
//   is moved into the output register.
// Reset: synchronous, active low rst_n; sequencer to idle, output register empty.
`timescale 1ns / 1ps

`include "card_number_luhn_brand_check_unit_macros.svh"

module card_number_luhn_brand_check_unit import lbc_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic clk,
  input  logic rst_n,
  lbc_in_if.sink    in_ch,
  lbc_out_if.source out_ch
);

  // ---------------------------------------------------------------------------
  // Sequencer state and scan datapath registers
  // ---------------------------------------------------------------------------
  state_t     state_r, state_nxt;
  bcd_t       scan_bcd_r, scan_bcd_nxt;   // digits, least significant at [3:0]
  logic [IDX_W-1:0] idx_r, idx_nxt;       // digit position under the scan
  digit_t     sum_r, sum_nxt;             // Luhn sum kept modulo ten
  count_t     len_r, len_nxt;             // one past highest nonzero digit
  digit_t     hi_r, hi_nxt;               // leading digit
  digit_t     lo_r, lo_nxt;               // digit just below the leading one
  digit_t     prev_r, prev_nxt;           // digit seen on the previous step

  logic       out_valid_r, out_valid_nxt;
  logic       out_ok_r;
  count_t     out_cnt_r;
  class_t     out_cls_r;

  // FSM outputs
  logic       in_ready;
  logic       conv_start;
  logic       scan_load;
  logic       scan_step;
  logic       out_load;

  conv_stat_t conv_stat;
  bcd_t       conv_bcd;

  logic       in_beat;
  logic       out_free;

  assign in_beat  = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // ---------------------------------------------------------------------------
  // Binary to BCD converter: one shared add-3 row, one shift per cycle
  // ---------------------------------------------------------------------------
  lbc_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .value (in_ch.card_value),
    .stat  (conv_stat),
    .bcd   (conv_bcd)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_stat.done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the finished result until the output register frees up
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    scan_load = 1'b0;
    scan_step = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_CONV: scan_load = conv_stat.done;
      ST_SCAN: scan_step = 1'b1;
      ST_DONE: out_load  = out_free;
      default: in_ready  = 1'b0;
    endcase
  end

  assign conv_start  = in_beat;
  assign in_ch.ready = in_ready;

  // ---------------------------------------------------------------------------
  // Digit scan: one decimal digit per cycle, least significant first.
  // Odd positions are doubled and folded back below ten; the running sum
  // stays modulo ten, so no wide adder or divider is needed.
  // ---------------------------------------------------------------------------
  digit_t          cur_digit;
  logic [DIGIT_W:0] dbl;
  digit_t          luhn_digit;
  logic [DIGIT_W:0] sum_wide;

  assign cur_digit = scan_bcd_r[DIGIT_W-1:0];
  assign dbl       = {cur_digit, 1'b0};

  always_comb begin
    if (idx_r[0]) begin
      luhn_digit = (dbl > (DIGIT_W+1)'(9)) ? DIGIT_W'(dbl - (DIGIT_W+1)'(9))
                                           : DIGIT_W'(dbl);
    end else begin
      luhn_digit = cur_digit;
    end
  end

  assign sum_wide = {1'b0, sum_r} + {1'b0, luhn_digit};

  always_comb begin
    scan_bcd_nxt = scan_bcd_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    len_nxt      = len_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    prev_nxt     = prev_r;
    priority if (scan_load) begin
      scan_bcd_nxt = conv_bcd;
      idx_nxt      = '0;
      sum_nxt      = '0;
      len_nxt      = '0;
      hi_nxt       = '0;
      lo_nxt       = '0;
      prev_nxt     = '0;
    end else if (scan_step) begin
      // advance to the next digit
      scan_bcd_nxt = {{DIGIT_W{1'b0}}, scan_bcd_r[BCD_W-1:DIGIT_W]};
      idx_nxt      = idx_r + 1'b1;
      sum_nxt      = (sum_wide >= (DIGIT_W+1)'(10)) ? DIGIT_W'(sum_wide - (DIGIT_W+1)'(10))
                                                    : DIGIT_W'(sum_wide);
      prev_nxt     = cur_digit;
      if (cur_digit != '0) begin
        // a nonzero digit becomes the new leading digit
        len_nxt = COUNT_W'(idx_r) + 1'b1;
        hi_nxt  = cur_digit;
        lo_nxt  = prev_r;
      end
    end else begin
      // hold the scan registers
      idx_nxt = idx_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Result: saturate overlong numbers, class only on a passing check
  // ---------------------------------------------------------------------------
  logic   too_long;
  logic   res_ok;
  count_t res_cnt;
  class_t res_cls;

  assign too_long = len_r > COUNT_W'(MAX_DIGITS);
  assign res_ok   = (sum_r == '0) && !too_long;
  assign res_cnt  = too_long ? COUNT_W'(MAX_DIGITS + 1) : len_r;
  assign res_cls  = res_ok ? lbc_classify(len_r, hi_r, lo_r) : CLS_INVALID;

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      // drop the beat once it is taken
      out_valid_nxt = 1'b0;
    end else begin
      // hold the beat while the sink stalls
      out_valid_nxt = out_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_bcd_r <= scan_bcd_nxt;
    sum_r      <= sum_nxt;
    len_r      <= len_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    prev_r     <= prev_nxt;
    if (out_load) begin
      out_ok_r  <= res_ok;
      out_cnt_r <= res_cnt;
      out_cls_r <= res_cls;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.luhn_ok      = out_ok_r;
  assign out_ch.digit_count  = out_cnt_r;
  assign out_ch.issuer_class = out_cls_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LBC_ASSERT_IMP(a_conv_alive, state_r == ST_CONV, conv_stat.busy || conv_stat.done, "converter idle while sequencer waits")
  `LBC_ASSERT_NXT(a_scan_end, (state_r == ST_SCAN) && (idx_r == LAST_IDX), state_r == ST_DONE, "scan did not finish after last digit")
  `LBC_ASSERT_IMP(a_cls_needs_ok, out_valid_r && (out_cls_r != CLS_INVALID), out_ok_r, "issuer class given without Luhn pass")
  `LBC_ASSERT_IMP(a_long_fails, out_valid_r && (out_cnt_r > COUNT_W'(MAX_DIGITS)), !out_ok_r, "overlong number passed the check")

endmodule
